// ===== rtl/core/mhpq_pkg.sv =====
// ============================================================================
// mhpq_pkg
// Shared types, codes and helpers of the max heap priority queue.
// ============================================================================
package mhpq_pkg;

    // Default number of heap entries.
    localparam int DEF_HEAP_DEPTH = 128;

    // Width of the entry count carried in a result.
    localparam int OUT_CNT_W = 8;

    // Operation codes.
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One heap entry as it sits in the store.
    typedef struct packed {
        logic signed [15:0] rating;
        logic [15:0]        tag;
    } t_word;

    // Payload of an input transfer.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] key_rating;
        logic [15:0]        entry_tag;
    } t_in_item;

    // Payload of a result transfer.
    typedef struct packed {
        logic signed [15:0]   top_rating;
        logic [15:0]          top_tag;
        logic                 is_empty;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [1:0]           status;
    } t_out_item;

    // True when entry a outranks entry b (strictly greater rating).
    function automatic logic rating_gt(input t_word a, input t_word b);
        return a.rating > b.rating;
    endfunction

endpackage

// ===== rtl/core/max_heap_priority_queue.sv =====
// ============================================================================
// max_heap_priority_queue
// Binary max heap of rated, tagged entries with insert, remove-max and read.
// ============================================================================
// Usage: an input transfer (i_in_valid high, o_in_stall low) carries one
// operation: insert an entry, remove the maximum, or only read. Every
// operation returns exactly one result transfer on the output channel
// (o_out_valid high, i_out_stall low) with the root entry, the entry count,
// an empty flag and a status. An insert on a full heap or a remove on an
// empty heap changes nothing and reports the rejection in the status.
// Operations are handled one at a time; the heap store is a single memory
// with registered read data. An insert reads the parent of the new entry
// and moves it down once per level climbed; a remove first fetches the last
// entry, then reads the children of the hole for each level descended.
// Reset empties the heap at once by clearing the count; the store itself
// is not cleared. When the receiver stalls, the finished result waits in
// the output register while the next operation is already accepted and
// run; that operation then holds until the register frees up.
// ============================================================================
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(HEAP_DEPTH);

    logic              eng_idle;
    logic              eng_done;
    t_out_item         eng_result;
    logic              in_accept;
    logic              out_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_word             mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    t_word             mem_rdata;
    logic              r_out_valid;
    t_out_item         r_out;

    // The engine takes a new operation only when it has nothing in flight.
    assign o_in_stall = !eng_idle;
    assign in_accept  = i_in_valid && eng_idle;

    // A finished result moves into the output register when that register
    // is empty or its content is transferred in this same cycle.
    assign out_load = eng_done && (!r_out_valid || !i_out_stall);

    mhpq_engine #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_accept),
        .i_item      (i_in_item),
        .o_idle      (eng_idle),
        .o_done      (eng_done),
        .o_result    (eng_result),
        .i_take      (out_load),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    mhpq_ram #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= eng_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // An empty heap reports a zero root entry.
    a_empty_zero_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_empty |-> r_out.top_rating == '0 && r_out.top_tag == '0)
        else $error("empty result carries a nonzero root entry");

    // A rejected insert happens only with the heap at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_FULL |->
            r_out.entry_count == OUT_CNT_W'(HEAP_DEPTH))
        else $error("insert rejected although the heap is not full");

    // A rejected remove happens only on an empty heap.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_EMPTY |-> r_out.is_empty)
        else $error("remove rejected although the heap holds entries");
`endif

endmodule

// ===== rtl/core/mhpq_ram.sv =====
// ============================================================================
// mhpq_ram
// Heap store: one write port and one read port with registered read data.
// ============================================================================
module mhpq_ram
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    localparam int ADDR_W = $clog2(HEAP_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_word             i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_word             o_rdata
);

    t_word r_mem [HEAP_DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mhpq_engine.sv =====
// ============================================================================
// mhpq_engine
// Sequencer that runs one heap operation at a time against the heap store.
// ============================================================================
module mhpq_engine
    import mhpq_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    localparam int ADDR_W = $clog2(HEAP_DEPTH),
    localparam int CNT_W  = $clog2(HEAP_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    output logic              o_idle,
    output logic              o_done,
    output t_out_item         o_result,
    input  logic              i_take,
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output t_word             o_mem_wdata,
    output logic              o_mem_re,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  t_word             i_mem_rdata
);

    localparam int IDX_W = CNT_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [ADDR_W-1:0] r_par, n_par;
    t_word             r_mov, n_mov;
    t_word             r_lw, n_lw;
    t_word             r_top, n_top;
    logic [1:0]        r_status, n_status;

    logic [IDX_W-1:0]  lc_idx;
    logic [IDX_W-1:0]  rc_idx;
    logic              has_l;
    logic              has_r;
    logic [ADDR_W-1:0] parent;
    logic              l_wins;
    logic              r_wins;
    t_word             cand;

    // Child and parent positions of the current hole.
    assign lc_idx = IDX_W'({r_pos, 1'b1});
    assign rc_idx = lc_idx + IDX_W'(1);
    assign has_l  = lc_idx < IDX_W'(r_cnt);
    assign has_r  = rc_idx < IDX_W'(r_cnt);
    assign parent = (r_pos - ADDR_W'(1)) >> 1;

    // Sift-down choice: the moving entry stays on ties, left wins over right on ties.
    assign l_wins = rating_gt(r_lw, r_mov);
    assign cand   = l_wins ? r_lw : r_mov;
    assign r_wins = rating_gt(i_mem_rdata, cand);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_par       = r_par;
        n_mov       = r_mov;
        n_lw        = r_lw;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = r_mov;
        o_mem_re    = 1'b0;
        o_mem_raddr = lc_idx[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                    case (i_item.mode)
                        MODE_INSERT: begin
                            if (r_cnt == CNT_W'(HEAP_DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_mov   = '{rating: i_item.key_rating, tag: i_item.entry_tag};
                                n_pos   = ADDR_W'(r_cnt);
                                n_cnt   = r_cnt + CNT_W'(1);
                                n_state = S_UP;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                            end else if (r_cnt == CNT_W'(1)) begin
                                n_cnt = '0;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = ADDR_W'(r_cnt - CNT_W'(1));
                                n_cnt       = r_cnt - CNT_W'(1);
                                n_pos       = '0;
                                n_state     = S_DN_LAST;
                            end
                        end
                        MODE_READ: begin
                            n_status = ST_DONE;
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_UP: begin
                if (r_pos == '0) begin
                    o_mem_we = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = parent;
                    n_par       = parent;
                    n_state     = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_mem_we = 1'b1;
                if (rating_gt(r_mov, i_mem_rdata)) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = r_par;
                    n_state     = S_UP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                n_mov   = i_mem_rdata;
                n_state = S_DN;
            end
            S_DN: begin
                if (has_l) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = lc_idx[ADDR_W-1:0];
                    n_state     = S_DN_L;
                end else begin
                    o_mem_we = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DN_L: begin
                if (has_r) begin
                    n_lw        = i_mem_rdata;
                    o_mem_re    = 1'b1;
                    o_mem_raddr = rc_idx[ADDR_W-1:0];
                    n_state     = S_DN_R;
                end else begin
                    o_mem_we = 1'b1;
                    if (rating_gt(i_mem_rdata, r_mov)) begin
                        o_mem_wdata = i_mem_rdata;
                        n_pos       = lc_idx[ADDR_W-1:0];
                        n_state     = S_DN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DN_R: begin
                o_mem_we = 1'b1;
                if (r_wins) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = rc_idx[ADDR_W-1:0];
                    n_state     = S_DN;
                end else if (l_wins) begin
                    o_mem_wdata = r_lw;
                    n_pos       = lc_idx[ADDR_W-1:0];
                    n_state     = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Shadow of the root entry, kept in step with every write to slot zero.
        n_top = (o_mem_we && o_mem_waddr == '0) ? o_mem_wdata : r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos    <= n_pos;
        r_par    <= n_par;
        r_mov    <= n_mov;
        r_lw     <= n_lw;
        r_top    <= n_top;
        r_status <= n_status;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_result.is_empty    = (r_cnt == '0);
        o_result.top_rating  = o_result.is_empty ? '0 : r_top.rating;
        o_result.top_tag     = o_result.is_empty ? '0 : r_top.tag;
        o_result.entry_count = OUT_CNT_W'(r_cnt);
        o_result.status      = r_status;
    end

endmodule
